[rtl/core/ssc_pkg.sv]
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and constants for the sensorless six-step commutator.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int unsigned STEP_W     = 3;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [STEP_W-1:0]  STEP_FIRST = 3'd1;
  localparam logic [STEP_W-1:0]  STEP_LAST  = 3'd6;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'd255;
  localparam logic [COUNT_W-1:0] HANDOFF_MIN_CROSSINGS = 8'd20;
  localparam int unsigned        HANDOFF_MAX_INTERVAL  = 2000;
  localparam logic [16:0]        POLL_HYSTERESIS       = 17'd500;

  typedef enum logic [1:0] {
    CMD_SAMPLE     = 2'd0,
    CMD_COMMUTATE  = 2'd1,
    CMD_ZERO_CROSS = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORWARD_DIR     = 3'd0,
    REG_INVERT_POLARITY = 3'd1,
    REG_MISMATCH_LIMIT  = 3'd2,
    REG_CHANGEOVER      = 3'd3,
    REG_ADVANCE         = 3'd4,
    REG_GUARDED_HANDOFF = 3'd5,
    REG_SPARE_6         = 3'd6,
    REG_SPARE_7         = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              rising;
    logic              wrapped;
  } step_upd_t;

endpackage

[rtl/core/ssc_step_seq.sv]
// ----------------------------------------------------------------------------
// ssc_step_seq
// Next commutation step, expected back-EMF polarity and wrap flag.
// ----------------------------------------------------------------------------
module ssc_step_seq (
  input  logic [ssc_pkg::STEP_W-1:0] step,
  input  logic                       forward_dir,
  input  logic                       invert_polarity,
  output ssc_pkg::step_upd_t         upd
);

  logic [ssc_pkg::STEP_W-1:0] next_step;
  logic                       wrap;
  logic                       rising;

  always_comb begin
    if (forward_dir) begin
      if (step >= ssc_pkg::STEP_LAST) begin
        next_step = ssc_pkg::STEP_FIRST;
        wrap      = 1'b1;
      end else begin
        next_step = step + 3'd1;
        wrap      = 1'b0;
      end
      rising = next_step[0];
    end else begin
      if (step <= ssc_pkg::STEP_FIRST || step > ssc_pkg::STEP_LAST) begin
        next_step = ssc_pkg::STEP_LAST;
        wrap      = 1'b1;
      end else begin
        next_step = step - 3'd1;
        wrap      = 1'b0;
      end
      rising = ~next_step[0];
    end
  end

  assign upd.step    = next_step;
  assign upd.rising  = rising ^ invert_polarity;
  assign upd.wrapped = wrap;

endmodule

[rtl/core/sensorless_six_step_commutator.sv]
// ----------------------------------------------------------------------------
// sensorless_six_step_commutator
// Sensorless BLDC six-step commutation with back-EMF sample counting.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream in_*: one event per transaction. in_tuser carries the
//   command (sample, commutate, zero-cross); in_tdata carries comparator
//   level, brake, average interval and timer count.
//   Output stream out_*: exactly one result per input transaction, giving
//   step, polarity, match count, mode, filtered interval, advance and the
//   drive, wrap and closed-loop pulses after the event.
//   Config port: cfg_wr_en with cfg_index and cfg_wdata writes one register;
//   write only while no transaction is in flight.
//   Result: registered; valid in the cycle after the input transaction.
//   Throughput: one event per clock while no result is held; state and result
//   register update on the same edge, so the next event may follow immediately.
//   Stall: a held result keeps in_tready low until out_tready takes it;
//   in_tready returns in the cycle the result is taken.
//   Reset: rst_n low (synchronous) returns registers to defaults, step 1,
//   poll mode on, counters and interval cleared, output empty.
// ----------------------------------------------------------------------------
module sensorless_six_step_commutator #(
  parameter int unsigned INTERVAL_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: comparator_level[0], brake_active[1], average_interval[17:2],
  //           timer_count[33:18], zero fill [39:34]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ssc_pkg::IN_DATA_W-1:0]      in_tdata,
  // in_tuser: command[1:0]
  input  logic [1:0]                         in_tuser,
  // out_tdata: phase_step[2:0], expect_rising[3], bemf_count[11:4],
  //            poll_mode[12], filtered_interval[28:13], advance_ticks[44:29],
  //            drive_update[45], wrapped[46], closed_loop_start[47]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ssc_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned IW = INTERVAL_BITS;
  localparam int unsigned CW = (IW > 16) ? IW : 16;
  localparam int unsigned SW = CW + 2;
  localparam int unsigned PW = IW + 6;

  // configuration
  logic        forward_dir_r;
  logic        invert_polarity_r;
  logic [7:0]  mismatch_limit_r;
  logic [15:0] changeover_r;
  logic [5:0]  advance_r;
  logic        guarded_r;

  // state
  logic [ssc_pkg::STEP_W-1:0]  step_r,     step_nxt;
  logic                        rising_r,   rising_nxt;
  logic [ssc_pkg::COUNT_W-1:0] match_r,    match_nxt;
  logic [ssc_pkg::COUNT_W-1:0] mismatch_r, mismatch_nxt;
  logic                        poll_r,     poll_nxt;
  logic [IW-1:0]               interval_r, interval_nxt;
  logic [ssc_pkg::COUNT_W-1:0] crossing_r, crossing_nxt;

  // output register
  logic                            out_valid_r, out_valid_nxt;
  logic [ssc_pkg::OUT_DATA_W-1:0]  out_data_r,  out_data_nxt;

  ssc_pkg::cmd_t      cmd;
  ssc_pkg::step_upd_t upd;
  logic               level;
  logic               brake;
  logic [15:0]        avg;
  logic [15:0]        tcount;
  logic               in_fire;
  logic               drive;
  logic               wrap;
  logic               start;
  logic [ssc_pkg::COUNT_W-1:0] mm_inc;
  logic [SW-1:0]      filt_sum;
  logic [PW-1:0]      adv_prod;
  logic [15:0]        adv_ticks;

  assign cmd    = ssc_pkg::cmd_t'(in_tuser);
  assign level  = in_tdata[0];
  assign brake  = in_tdata[1];
  assign avg    = in_tdata[17:2];
  assign tcount = in_tdata[33:18];

  assign in_tready  = ~out_valid_r | out_tready;
  assign in_fire    = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  ssc_step_seq u_step_seq (
    .step            (step_r),
    .forward_dir     (forward_dir_r),
    .invert_polarity (invert_polarity_r),
    .upd             (upd)
  );

  assign filt_sum = SW'(tcount) + SW'({interval_r, 1'b0}) + SW'(interval_r);
  assign mm_inc   = (mismatch_r < ssc_pkg::COUNT_MAX) ? mismatch_r + 8'd1 : mismatch_r;

  always_comb begin
    step_nxt     = step_r;
    rising_nxt   = rising_r;
    match_nxt    = match_r;
    mismatch_nxt = mismatch_r;
    poll_nxt     = poll_r;
    interval_nxt = interval_r;
    crossing_nxt = crossing_r;
    drive        = 1'b0;
    wrap         = 1'b0;
    start        = 1'b0;
    unique case (cmd)
      ssc_pkg::CMD_SAMPLE: begin
        if (~level == rising_r) begin
          match_nxt = (match_r < ssc_pkg::COUNT_MAX) ? match_r + 8'd1 : match_r;
        end else begin
          mismatch_nxt = mm_inc;
          if (mm_inc > mismatch_limit_r) begin
            match_nxt = '0;
          end
        end
      end
      ssc_pkg::CMD_COMMUTATE, ssc_pkg::CMD_ZERO_CROSS: begin
        step_nxt   = upd.step;
        rising_nxt = upd.rising;
        wrap       = upd.wrapped;
        drive      = ~brake;
        match_nxt  = '0;
        if ({1'b0, avg} > 17'(changeover_r) + ssc_pkg::POLL_HYSTERESIS) begin
          poll_nxt = 1'b1;
        end
        if (cmd == ssc_pkg::CMD_ZERO_CROSS) begin
          interval_nxt = filt_sum[IW+1:2];
          mismatch_nxt = '0;
          crossing_nxt = (crossing_r < ssc_pkg::COUNT_MAX) ? crossing_r + 8'd1
                                                           : crossing_r;
          if (guarded_r) begin
            start = (crossing_nxt >= ssc_pkg::HANDOFF_MIN_CROSSINGS) &&
                    (CW'(interval_nxt) <= CW'(ssc_pkg::HANDOFF_MAX_INTERVAL));
          end else begin
            start = CW'(interval_nxt) < CW'(changeover_r);
          end
          if (start) begin
            poll_nxt = 1'b0;
          end
        end
      end
      ssc_pkg::CMD_NONE: begin
      end
      default: begin
      end
    endcase
  end

  assign adv_prod  = PW'(advance_r) * PW'(interval_nxt);
  assign adv_ticks = 16'(adv_prod >> 6);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {start, wrap, drive, adv_ticks, 16'(interval_nxt),
                       poll_nxt, match_nxt, rising_nxt, step_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      forward_dir_r     <= 1'b1;
      invert_polarity_r <= 1'b0;
      mismatch_limit_r  <= 8'd2;
      changeover_r      <= 16'd2500;
      advance_r         <= 6'd16;
      guarded_r         <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (ssc_pkg::reg_idx_t'(cfg_index))
        ssc_pkg::REG_FORWARD_DIR:     forward_dir_r     <= cfg_wdata[0];
        ssc_pkg::REG_INVERT_POLARITY: invert_polarity_r <= cfg_wdata[0];
        ssc_pkg::REG_MISMATCH_LIMIT:  mismatch_limit_r  <= cfg_wdata[7:0];
        ssc_pkg::REG_CHANGEOVER:      changeover_r      <= cfg_wdata;
        ssc_pkg::REG_ADVANCE:         advance_r         <= cfg_wdata[5:0];
        ssc_pkg::REG_GUARDED_HANDOFF: guarded_r         <= cfg_wdata[0];
        ssc_pkg::REG_SPARE_6, ssc_pkg::REG_SPARE_7: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ssc_pkg::STEP_FIRST;
      rising_r    <= 1'b0;
      match_r     <= '0;
      mismatch_r  <= '0;
      poll_r      <= 1'b1;
      interval_r  <= '0;
      crossing_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        step_r     <= step_nxt;
        rising_r   <= rising_nxt;
        match_r    <= match_nxt;
        mismatch_r <= mismatch_nxt;
        poll_r     <= poll_nxt;
        interval_r <= interval_nxt;
        crossing_r <= crossing_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
